@@ hdl/cha_pkg.sv @@
package cha_pkg;

  // table geometry
  localparam int MAX_HOLES = 16;
  localparam int SIZE_BITS = 16;

  localparam int IDX_BITS  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int FREE_BITS = SIZE_BITS + IDX_BITS;

  // fixed port widths
  localparam int OPCODE_W = 2;
  localparam int INSIZE_W = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;
  localparam int LEFT_W   = 16;
  localparam int TOTAL_W  = 20;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTORE = 2'd2,
    OP_ALLOC   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2,
    STRAT_NEXT  = 2'd3
  } strategy_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RESTORE,
    BS_SCAN,
    BS_DONE
  } back_state_t;

  typedef struct packed {
    opcode_t              kind;
    logic [SIZE_BITS-1:0] size;
  } cmd_t;

  function automatic logic [SIZE_BITS-1:0] to_size(input logic [INSIZE_W-1:0] v);
    logic [SIZE_BITS+INSIZE_W-1:0] e;
    e = {{SIZE_BITS{1'b0}}, v};
    return e[SIZE_BITS-1:0];
  endfunction

  function automatic logic [INDEX_W-1:0] to_index(input logic [IDX_BITS-1:0] v);
    logic [IDX_BITS+INDEX_W-1:0] e;
    e = {{INDEX_W{1'b0}}, v};
    return e[INDEX_W-1:0];
  endfunction

  function automatic logic [LEFT_W-1:0] to_left(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS+LEFT_W-1:0] e;
    e = {{LEFT_W{1'b0}}, v};
    return e[LEFT_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [FREE_BITS-1:0] v);
    logic [FREE_BITS+TOTAL_W-1:0] e;
    e = {{TOTAL_W{1'b0}}, v};
    return (e > {{FREE_BITS{1'b0}}, TOTAL_MAX}) ? TOTAL_MAX : e[TOTAL_W-1:0];
  endfunction

endpackage

@@ hdl/cha_ram.sv @@
module cha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cha_front.sv @@
module cha_front
  import cha_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [INSIZE_W-1:0] size,
  output logic                cmd_valid,
  output cmd_t                cmd,
  input  logic                cmd_take
);

  cmd_t                 q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] fill;
  cmd_t                 in_cmd;
  logic                 do_push;
  logic                 do_pop;

  // classify the incoming word
  always_comb begin
    in_cmd.kind = opcode_t'(opcode);
    in_cmd.size = to_size(size);
  end

  assign full      = (fill == QCNT_BITS'(QUEUE_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + 1'b1))
    else $error("push not counted");

  a_pop_counts: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (fill == $past(fill) - 1'b1))
    else $error("pop not counted");

endmodule

@@ hdl/cha_back.sv @@
module cha_back
  import cha_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  strategy_t           strategy,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_take,
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  hole_index,
  output logic [LEFT_W-1:0]   hole_left,
  output logic [TOTAL_W-1:0]  total_free
);

  back_state_t state;
  back_state_t state_next;

  logic [CNT_BITS-1:0]  hole_count;
  logic [IDX_BITS-1:0]  next_pointer;
  logic [FREE_BITS-1:0] free_sum;

  logic [SIZE_BITS-1:0] op_size;
  logic [CNT_BITS-1:0]  iss;
  logic                 rd_pend;
  logic [IDX_BITS-1:0]  rd_addr_d;
  logic [IDX_BITS-1:0]  scan_start;
  logic                 found;
  logic [IDX_BITS-1:0]  pick;
  logic [SIZE_BITS-1:0] best;

  status_t              res_status;
  logic [IDX_BITS-1:0]  res_index;
  logic [SIZE_BITS-1:0] res_left;

  logic                 out_valid;
  status_t              out_status;
  logic [INDEX_W-1:0]   out_index;
  logic [LEFT_W-1:0]    out_left;
  logic [TOTAL_W-1:0]   out_total;

  logic                 table_full;
  logic                 issue_more;
  logic                 pipe_done;
  logic [CNT_BITS:0]    k_sum;
  logic [CNT_BITS:0]    k_wrap;
  logic [IDX_BITS-1:0]  k_addr;
  logic                 fit;
  logic                 upd;
  logic                 load_out;
  logic [SIZE_BITS-1:0] alloc_left;

  logic                 tot_we;
  logic [SIZE_BITS-1:0] tot_rdata;
  logic                 rem_we;
  logic [IDX_BITS-1:0]  rem_waddr;
  logic [SIZE_BITS-1:0] rem_wdata;
  logic [SIZE_BITS-1:0] rem_rdata;

  cha_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_HOLES)) u_total (
    .clk   (clk),
    .we    (tot_we),
    .waddr (hole_count[IDX_BITS-1:0]),
    .wdata (cmd.size),
    .raddr (iss[IDX_BITS-1:0]),
    .rdata (tot_rdata)
  );

  cha_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_HOLES)) u_remaining (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (k_addr),
    .rdata (rem_rdata)
  );

  // datapath helpers
  always_comb begin
    table_full = (hole_count >= CNT_BITS'(MAX_HOLES));
    issue_more = (iss < hole_count);
    pipe_done  = !issue_more && !rd_pend;
    // scan order wraps past the last hole for next fit
    k_sum      = {2'b00, scan_start} + {1'b0, iss};
    k_wrap     = (k_sum >= {1'b0, hole_count}) ? k_sum - {1'b0, hole_count} : k_sum;
    k_addr     = k_wrap[IDX_BITS-1:0];
    fit        = (op_size <= rem_rdata);
    upd        = (state == BS_SCAN) && rd_pend && fit &&
                 (!found ||
                  (strategy == STRAT_BEST  && rem_rdata < best) ||
                  (strategy == STRAT_WORST && rem_rdata > best));
    alloc_left = best - op_size;
    load_out   = (state == BS_DONE) && (!out_valid || pop);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            OP_CLEAR:   state_next = BS_DONE;
            OP_APPEND:  state_next = BS_DONE;
            OP_RESTORE: state_next = BS_RESTORE;
            OP_ALLOC:   state_next = BS_SCAN;
          endcase
        end
      end
      BS_RESTORE: begin
        if (pipe_done) state_next = BS_DONE;
      end
      BS_SCAN: begin
        if (pipe_done) state_next = BS_DONE;
      end
      BS_DONE: begin
        if (!out_valid || pop) state_next = BS_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_take  = 1'b0;
    tot_we    = 1'b0;
    rem_we    = 1'b0;
    rem_waddr = hole_count[IDX_BITS-1:0];
    rem_wdata = cmd.size;
    unique case (state)
      BS_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid && cmd.kind == OP_APPEND && !table_full) begin
          tot_we = 1'b1;
          rem_we = 1'b1;
        end
      end
      BS_RESTORE: begin
        rem_we    = rd_pend;
        rem_waddr = rd_addr_d;
        rem_wdata = tot_rdata;
      end
      BS_SCAN: begin
        rem_we    = pipe_done && found;
        rem_waddr = pick;
        rem_wdata = alloc_left;
      end
      BS_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BS_IDLE;
      hole_count   <= '0;
      next_pointer <= '0;
      free_sum     <= '0;
      iss          <= '0;
      rd_pend      <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        BS_IDLE: begin
          if (cmd_valid) begin
            op_size    <= cmd.size;
            iss        <= '0;
            rd_pend    <= 1'b0;
            found      <= 1'b0;
            scan_start <= (strategy == STRAT_NEXT && {1'b0, next_pointer} < hole_count)
                          ? next_pointer : '0;
            unique case (cmd.kind)
              OP_CLEAR: begin
                hole_count   <= '0;
                next_pointer <= '0;
                free_sum     <= '0;
                res_status   <= ST_DONE;
                res_index    <= '0;
                res_left     <= '0;
              end
              OP_APPEND: begin
                if (table_full) begin
                  res_status <= ST_FULL;
                  res_index  <= '0;
                  res_left   <= '0;
                end else begin
                  hole_count <= hole_count + 1'b1;
                  free_sum   <= free_sum + {{IDX_BITS{1'b0}}, cmd.size};
                  res_status <= ST_DONE;
                  res_index  <= hole_count[IDX_BITS-1:0];
                  res_left   <= cmd.size;
                end
              end
              OP_RESTORE: begin
                free_sum     <= '0;
                next_pointer <= '0;
                res_status   <= ST_DONE;
                res_index    <= '0;
                res_left     <= '0;
              end
              OP_ALLOC: begin
              end
            endcase
          end
        end
        BS_RESTORE: begin
          if (issue_more) iss <= iss + 1'b1;
          rd_pend   <= issue_more;
          rd_addr_d <= iss[IDX_BITS-1:0];
          if (rd_pend) begin
            free_sum <= free_sum + {{IDX_BITS{1'b0}}, tot_rdata};
          end
        end
        BS_SCAN: begin
          if (issue_more) iss <= iss + 1'b1;
          rd_pend   <= issue_more;
          rd_addr_d <= k_addr;
          if (upd) begin
            found <= 1'b1;
            pick  <= rd_addr_d;
            best  <= rem_rdata;
          end
          if (pipe_done) begin
            if (found) begin
              free_sum     <= free_sum - {{IDX_BITS{1'b0}}, op_size};
              next_pointer <= pick;
              res_status   <= ST_DONE;
              res_index    <= pick;
              res_left     <= alloc_left;
            end else begin
              res_status <= ST_NO_FIT;
              res_index  <= '0;
              res_left   <= '0;
            end
          end
        end
        BS_DONE: begin
        end
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_index  <= to_index(res_index);
      out_left   <= to_left(res_left);
      out_total  <= sat_total(free_sum);
    end
  end

  assign empty      = !out_valid;
  assign status     = out_status;
  assign hole_index = out_index;
  assign hole_left  = out_left;
  assign total_free = out_total;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hole_count <= CNT_BITS'(MAX_HOLES))
    else $error("hole count past table size");

  a_pick_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == BS_SCAN && found) |-> ({1'b0, pick} < hole_count))
    else $error("picked hole outside table");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == BS_IDLE && cmd_valid && cmd.kind == OP_CLEAR) |=>
      (hole_count == '0 && free_sum == '0))
    else $error("clear left state behind");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd_valid) |=> (state != BS_IDLE))
    else $error("taken word not being worked");

endmodule

@@ hdl/contiguous_hole_allocator.sv @@
// contiguous hole allocator: keeps a table of up to MAX_HOLES memory holes
// (total and remaining size each) and serves words of opcode and size through
// a push/full input queue and an empty/pop result queue. opcodes clear the
// table, append a hole, restore all remaining sizes (and reset the next-fit
// pointer), or allocate a request by the strategy register (first, best,
// worst or next fit; ties go to the first hole in scan order, the lowest index
// but for next fit). each word gives one result word: status, hole index, that
// hole's remaining size and the total free. the back end scans the remaining
// size memory one entry per cycle through its single read port. an allocate or
// restore goes from idle through the restore or scan state to done, which loads
// the result register; clear or append goes from idle straight to done. the
// input queue keeps taking words, until full, while the back end works or a
// result waits to be popped. write the strategy register only while idle.
module contiguous_hole_allocator
  import cha_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input word queue
  input  logic                push,
  output logic                full,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [INSIZE_W-1:0] size,
  // result word queue
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  hole_index,
  output logic [LEFT_W-1:0]   hole_left,
  output logic [TOTAL_W-1:0]  total_free,
  // strategy register write
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data
);

  strategy_t strategy;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_take;

  // strategy register, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy <= STRAT_FIRST;
    end else if (cfg_we) begin
      strategy <= strategy_t'(cfg_data);
    end
  end

  // front: accept and classify words into the short queue
  cha_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .size      (size),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: hole table, scan engine and result register
  cha_back u_back (
    .clk        (clk),
    .rst        (rst),
    .strategy   (strategy),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .hole_index (hole_index),
    .hole_left  (hole_left),
    .total_free (total_free)
  );

endmodule
